FILE: hdl/sync_checksum_frame_receiver_top_assert.svh
// Assertion macros for the sync checksum frame receiver.
// No dependencies; taken in by the top level with `include.
`ifndef SYNC_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SYNC_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTH

// cond must never hold outside reset
`define SCFR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// ante in a cycle implies cons in the same cycle
`define SCFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante in a cycle implies cons in the next cycle
`define SCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCFR_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define SCFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/scfr_pkg.sv
// Shared constants and types for the sync checksum frame receiver.
// No dependencies.
package scfr_pkg;

    localparam int FRAME_LEN_DEF = 8;
    localparam int PAYLOAD_COUNT = 5;
    localparam int PAYLOAD_FIRST = 2;

    typedef logic [7:0] byte_t;

    localparam byte_t SYNC_RESET = 8'hFF;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SYNC = 2'd1;
    localparam logic [1:0] STAT_BAD_SUM  = 2'd2;

    // received word as held in the input register
    typedef struct packed {
        byte_t rx_byte;
        logic  restart;
    } rx_word_t;

    // one frame result
    typedef struct packed {
        logic [1:0]                    frame_status;
        byte_t                         mode_code;
        byte_t [PAYLOAD_COUNT-1:0]     payload;
    } result_word_t;

    // core status toward the top level
    typedef struct packed {
        logic produce;
        logic pos_bad;
    } core_flags_t;

endpackage

FILE: hdl/scfr_if.sv
// Channel interfaces: received words, frame results, configuration writes.
// Depends on scfr_pkg.
interface scfr_rx_if;
    logic                valid;
    logic                ready;
    scfr_pkg::byte_t     rx_byte;
    logic                restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface scfr_result_if;
    logic                valid;
    logic                ready;
    logic [1:0]          frame_status;
    scfr_pkg::byte_t     mode_code;
    scfr_pkg::byte_t     payload_0;
    scfr_pkg::byte_t     payload_1;
    scfr_pkg::byte_t     payload_2;
    scfr_pkg::byte_t     payload_3;
    scfr_pkg::byte_t     payload_4;

    modport source (output valid, output frame_status, output mode_code,
                    output payload_0, output payload_1, output payload_2,
                    output payload_3, output payload_4, input ready);
    modport sink   (input valid, input frame_status, input mode_code,
                    input payload_0, input payload_1, input payload_2,
                    input payload_3, input payload_4, output ready);
endinterface

interface scfr_cfg_if;
    logic                valid;
    logic                ready;
    scfr_pkg::byte_t     sync_value;

    modport source (output valid, output sync_value, input ready);
    modport sink   (input valid, input sync_value, output ready);
endinterface

FILE: hdl/scfr_in_reg.sv
// Input register: captures one received word, frees when the core takes it.
// Depends on scfr_pkg and scfr_if.
module scfr_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    scfr_rx_if.sink            rx,
    input  logic               take,
    output logic               hold_valid,
    output scfr_pkg::rx_word_t hold_word
);

    logic               valid_reg;
    logic               valid_next;
    scfr_pkg::rx_word_t word_reg;
    logic               accept;

    assign rx.ready   = !valid_reg || take;
    assign accept     = rx.valid && rx.ready;
    assign hold_valid = valid_reg;
    assign hold_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.rx_byte <= rx.rx_byte;
            word_reg.restart <= rx.restart;
        end
    end

endmodule

FILE: hdl/scfr_frame_core.sv
// Frame core: position counter, running sum, held bytes, status check.
// Depends on scfr_pkg.
module scfr_frame_core #(
    parameter int FRAME_LEN = scfr_pkg::FRAME_LEN_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  scfr_pkg::rx_word_t     item,
    input  scfr_pkg::byte_t        sync_value,
    input  logic                   out_space,
    output logic                   take,
    output scfr_pkg::result_word_t res_word,
    output scfr_pkg::core_flags_t  flags
);

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    scfr_pkg::byte_t  sum_reg, sum_next;
    scfr_pkg::byte_t  first_reg, first_next;
    scfr_pkg::byte_t  mode_reg, mode_next;
    scfr_pkg::byte_t [scfr_pkg::PAYLOAD_COUNT-1:0] payload_reg;
    logic             at_last;

    // restart makes this word position zero
    assign pos_cur = item.restart ? '0 : pos_reg;
    assign at_last = (pos_cur == LAST);
    assign take    = item_valid && (!at_last || out_space);

    assign flags.produce = item_valid && at_last && out_space;
    assign flags.pos_bad = (pos_reg > LAST);

    always_comb
    begin
        if (first_reg != sync_value)
        begin
            res_word.frame_status = scfr_pkg::STAT_BAD_SYNC;
        end
        else if (sum_reg != item.rx_byte)
        begin
            res_word.frame_status = scfr_pkg::STAT_BAD_SUM;
        end
        else
        begin
            res_word.frame_status = scfr_pkg::STAT_OK;
        end
        res_word.mode_code = mode_reg;
        res_word.payload   = payload_reg;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        mode_next  = mode_reg;
        if (take)
        begin
            if (pos_cur == '0)
            begin
                first_next = item.rx_byte;
            end
            if (pos_cur == POS_W'(1))
            begin
                mode_next = item.rx_byte;
            end
            if (at_last || pos_cur == '0)
            begin
                sum_next = '0;
            end
            else
            begin
                sum_next = sum_reg + item.rx_byte;
            end
            pos_next = at_last ? '0 : pos_cur + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            first_reg <= '0;
            mode_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            first_reg <= first_next;
            mode_reg  <= mode_next;
        end
    end

    // payload store, no reset: every entry is written before it is read
    for (genvar k = 0; k < scfr_pkg::PAYLOAD_COUNT; k++)
    begin : g_payload
        always_ff @(posedge clk)
        begin
            if (take && pos_cur == POS_W'(scfr_pkg::PAYLOAD_FIRST + k))
            begin
                payload_reg[k] <= item.rx_byte;
            end
        end
    end

endmodule

FILE: hdl/scfr_out_reg.sv
// Result register: holds one frame result until the sink takes it.
// Depends on scfr_pkg and scfr_if.
module scfr_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  scfr_pkg::result_word_t res_word,
    output logic                   space,
    scfr_result_if.source          result
);

    logic                   valid_reg;
    logic                   valid_next;
    scfr_pkg::result_word_t word_reg;

    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= res_word;
        end
    end

    assign result.valid        = valid_reg;
    assign result.frame_status = word_reg.frame_status;
    assign result.mode_code    = word_reg.mode_code;
    assign result.payload_0    = word_reg.payload[0];
    assign result.payload_1    = word_reg.payload[1];
    assign result.payload_2    = word_reg.payload[2];
    assign result.payload_3    = word_reg.payload[3];
    assign result.payload_4    = word_reg.payload[4];

endmodule

FILE: hdl/sync_checksum_frame_receiver_top.sv
// Sync checksum frame receiver, top level.
// Throughput: one received word per cycle while the result side keeps up; a frame's
// last word waits in the input register while the result register is full and unread.
// A frame's result word is formed from its last word in the input register and then
// held in the result register. Reset (rst_n, async, low): pipeline empty, frame
// position zero, sync value 0xFF. Depends on scfr_pkg, scfr_if and submodules.
module sync_checksum_frame_receiver_top #(
    parameter int FRAME_LEN = scfr_pkg::FRAME_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    scfr_rx_if.sink       rx,
    scfr_result_if.source result,
    scfr_cfg_if.sink      cfg
);

`include "sync_checksum_frame_receiver_top_assert.svh"

    // sync byte register; the user must write it only while the block is idle, as the block has no check for this
    scfr_pkg::byte_t sync_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= scfr_pkg::SYNC_RESET;
        end
        else if (cfg.valid)
        begin
            sync_reg <= cfg.sync_value;
        end
    end

    logic                   hold_valid;
    scfr_pkg::rx_word_t     hold_word;
    logic                   take;
    logic                   out_space;
    scfr_pkg::result_word_t res_word;
    scfr_pkg::core_flags_t  flags;

    // stage one: received word register
    scfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_word  (hold_word)
    );

    // frame tracking and status check on the held word; a word that ends
    // a frame waits in stage one only while the result register is full and unread
    scfr_frame_core #(
        .FRAME_LEN (FRAME_LEN)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (hold_valid),
        .item       (hold_word),
        .sync_value (sync_reg),
        .out_space  (out_space),
        .take       (take),
        .res_word   (res_word),
        .flags      (flags)
    );

    // stage two: result register
    scfr_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (flags.produce),
        .res_word (res_word),
        .space    (out_space),
        .result   (result)
    );

    // checks
    `SCFR_ASSERT_NEVER(a_status_code, clk, rst_n, result.valid && result.frame_status == 2'd3, "undefined frame status")
    `SCFR_ASSERT_NEVER(a_pos_range, clk, rst_n, flags.pos_bad, "frame position past last byte")
    `SCFR_ASSERT_NEXT(a_held_word_kept, clk, rst_n, hold_valid && !take, hold_valid, "stalled word lost")
    `SCFR_ASSERT_IMPLY(a_result_room, clk, rst_n, flags.produce, out_space && take, "result loaded without room")

endmodule
